[src/art_pkg.sv]
// Package for the address region table: channel payload types, command and
// status codes, and the controller-to-datapath command bundle.
// No dependencies.
package art_pkg;

    localparam int FIELD_ADDR_W = 48;
    localparam int EXT_ADDR_W   = 64;

    localparam logic [1:0] CMD_ATTACH = 2'd0;
    localparam logic [1:0] CMD_DETACH = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_CONFLICT = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_BADLEN   = 3'd4;

    typedef struct packed {
        logic [1:0]              command;
        logic [31:0]             region_id;
        logic [15:0]             owner_tag;
        logic [FIELD_ADDR_W-1:0] address;
        logic [FIELD_ADDR_W-1:0] length;
    } art_in_t;

    typedef struct packed {
        logic [2:0]              status;
        logic                    hit;
        logic [31:0]             match_id;
        logic [15:0]             match_owner;
        logic [FIELD_ADDR_W-1:0] probe_address;
    } art_out_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic capture;  // latch a new request, clear scan state
        logic rd_en;    // read table entry at the scan index
        logic commit;   // update table, load result register
    } art_ctl_t;

endpackage

[src/art_ctrl.sv]
// Sequencer for the address region table: accepts a request, steps the scan
// index over every entry, then commits when the result register is free.
// Depends on art_pkg.
module art_ctrl
    import art_pkg::*;
#(
    parameter int REGIONS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_stall,
    output logic                res_valid,
    input  logic                res_stall,
    output art_ctl_t            ctl,
    output logic [(REGIONS > 1 ? $clog2(REGIONS) : 1)-1:0] rd_idx
);

    localparam int IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || !res_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign res_valid = out_valid_reg;
    assign rd_idx    = cnt_reg;

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ctl.capture = 1'b0;
        ctl.rd_en   = 1'b0;
        ctl.commit  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctl.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                ctl.rd_en = 1'b1;
                if (cnt_reg == IDX_W'(REGIONS - 1))
                    state_next = S_DRAIN;
                else
                    cnt_next = cnt_reg + IDX_W'(1);
            end
            S_DRAIN:
            begin
                // last read entry is evaluated this cycle
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    ctl.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctl.commit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !res_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[src/art_dp.sv]
// Datapath for the address region table: entry storage, valid bits, the
// per-entry compare logic of the scan and the result register.
// Depends on art_pkg.
module art_dp
    import art_pkg::*;
#(
    parameter int REGIONS    = 16,
    parameter int ADDR_WIDTH = 48
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  art_in_t  cmd_data,
    input  art_ctl_t ctl,
    input  logic [(REGIONS > 1 ? $clog2(REGIONS) : 1)-1:0] rd_idx,
    output art_out_t res_data
);

    localparam int IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int AW    = ADDR_WIDTH;

    // table storage
    logic [AW-1:0] mem_start [REGIONS];
    logic [AW-1:0] mem_end   [REGIONS];
    logic [31:0]   mem_id    [REGIONS];
    logic [15:0]   mem_owner [REGIONS];
    logic [REGIONS-1:0] valid_reg, valid_next;

    // latched request
    logic [1:0]              op_reg;
    logic [31:0]             id_reg;
    logic [15:0]             owner_reg;
    logic [AW-1:0]           start_reg;
    logic [AW-1:0]           last_reg;
    logic                    badlen_reg;
    logic [FIELD_ADDR_W-1:0] probe_reg;

    // read stage
    logic [AW-1:0]    rd_start_reg, rd_end_reg;
    logic [31:0]      rd_id_reg;
    logic [15:0]      rd_owner_reg;
    logic             proc_en_reg;
    logic [IDX_W-1:0] proc_idx_reg;

    // scan results
    logic             conflict_reg, conflict_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic             best_found_reg, best_found_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [AW-1:0]    best_start_reg, best_start_next;
    logic             hit_reg, hit_next;
    logic [31:0]      hit_id_reg, hit_id_next;
    logic [15:0]      hit_owner_reg, hit_owner_next;

    logic [EXT_ADDR_W-1:0] addr_ext, len_ext;
    logic [AW-1:0]         in_start, in_len;
    logic [AW:0]           end_sum;
    logic                  in_badlen;

    logic ent_valid, start_le_end, rstart_le_last, rstart_le_start;
    logic id_match, earlier, attach_ok;
    logic [2:0] status;

    // request decode: range end and length check, carry above AW means wrap
    assign addr_ext  = EXT_ADDR_W'(cmd_data.address);
    assign len_ext   = EXT_ADDR_W'(cmd_data.length);
    assign in_start  = addr_ext[AW-1:0];
    assign in_len    = len_ext[AW-1:0];
    assign end_sum   = {1'b0, in_start} + {1'b0, in_len} - {{AW{1'b0}}, 1'b1};
    assign in_badlen = (in_len == '0) || end_sum[AW];

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            op_reg     <= cmd_data.command;
            id_reg     <= cmd_data.region_id;
            owner_reg  <= cmd_data.owner_tag;
            start_reg  <= in_start;
            last_reg   <= end_sum[AW-1:0];
            badlen_reg <= in_badlen;
            probe_reg  <= cmd_data.address;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_start_reg <= mem_start[rd_idx];
            rd_end_reg   <= mem_end[rd_idx];
            rd_id_reg    <= mem_id[rd_idx];
            rd_owner_reg <= mem_owner[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit && attach_ok)
        begin
            mem_start[free_idx_reg] <= start_reg;
            mem_end[free_idx_reg]   <= last_reg;
            mem_id[free_idx_reg]    <= id_reg;
            mem_owner[free_idx_reg] <= owner_reg;
        end
    end

    // per-entry evaluation, one entry per cycle
    assign ent_valid       = proc_en_reg && valid_reg[proc_idx_reg];
    assign start_le_end    = (start_reg <= rd_end_reg);
    assign rstart_le_last  = (rd_start_reg <= last_reg);
    assign rstart_le_start = (rd_start_reg <= start_reg);
    assign id_match        = (rd_id_reg == id_reg) && (rd_owner_reg == owner_reg);
    assign earlier         = !best_found_reg || (rd_start_reg < best_start_reg);

    always_comb
    begin
        conflict_next   = conflict_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_start_next = best_start_reg;
        hit_next        = hit_reg;
        hit_id_next     = hit_id_reg;
        hit_owner_next  = hit_owner_reg;
        if (ctl.capture)
        begin
            conflict_next   = 1'b0;
            free_found_next = 1'b0;
            best_found_next = 1'b0;
            hit_next        = 1'b0;
        end
        else if (proc_en_reg)
        begin
            unique case (op_reg)
                CMD_ATTACH:
                begin
                    if (ent_valid)
                    begin
                        if (start_le_end && rstart_le_last)
                            conflict_next = 1'b1;
                    end
                    else if (!free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = proc_idx_reg;
                    end
                end
                CMD_DETACH:
                begin
                    if (ent_valid && id_match && earlier)
                    begin
                        best_found_next = 1'b1;
                        best_idx_next   = proc_idx_reg;
                        best_start_next = rd_start_reg;
                    end
                end
                CMD_LOOKUP:
                begin
                    // first containing entry wins
                    if (ent_valid && rstart_le_start && start_le_end && !hit_reg)
                    begin
                        hit_next       = 1'b1;
                        hit_id_next    = rd_id_reg;
                        hit_owner_next = rd_owner_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign attach_ok = (op_reg == CMD_ATTACH) && !badlen_reg && !conflict_reg
                       && free_found_reg;

    always_comb
    begin
        unique case (op_reg)
            CMD_ATTACH:
            begin
                priority if (badlen_reg)
                    status = ST_BADLEN;
                else if (conflict_reg)
                    status = ST_CONFLICT;
                else if (!free_found_reg)
                    status = ST_FULL;
                else
                    status = ST_OK;
            end
            CMD_DETACH: status = best_found_reg ? ST_OK : ST_NOTFOUND;
            CMD_LOOKUP: status = hit_reg ? ST_OK : ST_NOTFOUND;
            default:    status = ST_NOTFOUND;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.commit)
        begin
            if (attach_ok)
                valid_next[free_idx_reg] = 1'b1;
            else if ((op_reg == CMD_DETACH) && best_found_reg)
                valid_next[best_idx_reg] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            proc_en_reg    <= 1'b0;
            proc_idx_reg   <= '0;
            conflict_reg   <= 1'b0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            proc_en_reg    <= ctl.rd_en;
            proc_idx_reg   <= rd_idx;
            conflict_reg   <= conflict_next;
            free_found_reg <= free_found_next;
            best_found_reg <= best_found_next;
            hit_reg        <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        free_idx_reg   <= free_idx_next;
        best_idx_reg   <= best_idx_next;
        best_start_reg <= best_start_next;
        hit_id_reg     <= hit_id_next;
        hit_owner_reg  <= hit_owner_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.commit)
        begin
            res_data.status        <= status;
            res_data.hit           <= hit_reg && (op_reg == CMD_LOOKUP);
            res_data.match_id      <= (hit_reg && (op_reg == CMD_LOOKUP)) ? hit_id_reg : '0;
            res_data.match_owner   <= (hit_reg && (op_reg == CMD_LOOKUP)) ? hit_owner_reg : '0;
            res_data.probe_address <= probe_reg;
        end
    end

endmodule

[src/address_region_table.sv]
// Address region table: attach, detach and lookup of disjoint address ranges.
// Each request scans every entry, one per cycle through the table read port.
// A request is captured, scanned entry by entry, evaluated in a drain state and
// committed once the output register is free; a new request is taken
// while the previous result still waits in the output register.
// Reset empties the table at once (valid bits only); no clearing pass.
module address_region_table
    import art_pkg::*;
#(
    parameter int REGIONS    = 16,
    parameter int ADDR_WIDTH = 48
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  art_in_t  cmd_data,
    output logic     res_valid,
    input  logic     res_stall,
    output art_out_t res_data
);

    localparam int IDX_W = (REGIONS > 1) ? $clog2(REGIONS) : 1;

    art_ctl_t         ctl;
    logic [IDX_W-1:0] rd_idx;

    art_ctrl #(
        .REGIONS (REGIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .ctl       (ctl),
        .rd_idx    (rd_idx)
    );

    art_dp #(
        .REGIONS    (REGIONS),
        .ADDR_WIDTH (ADDR_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd_data (cmd_data),
        .ctl      (ctl),
        .rd_idx   (rd_idx),
        .res_data (res_data)
    );

endmodule

[verif/address_region_table_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for address_region_table: a directed table of corner cases,
// then phased random attach/detach/lookup traffic checked against a region table model.
// Depends on art_pkg and address_region_table.
module address_region_table_test;
    import art_pkg::*;

    localparam int          REGIONS      = 16;
    localparam int          N_PHASES     = 8;
    localparam int          PHASE_ITEMS  = 190;
    localparam int          DRAIN_CYCLES = 2 * REGIONS + 8;
    localparam int          N_DIRECTED   = 17;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;
    localparam logic [47:0] ADDR_MAX     = '1;

    typedef struct {
        art_in_t     req;
        int          reps;
        logic [47:0] stride;    // start address steps down by this on each repeat
        bit          typed;
        art_out_t    res;
    } region_case_t;

    logic     clk;
    logic     rst_n;
    logic     cmd_valid;
    logic     cmd_stall;
    art_in_t  cmd_data;
    logic     res_valid;
    logic     res_stall;
    art_out_t res_data;

    // Shadow copy of the region table
    logic [47:0] tbl_start [REGIONS];
    logic [47:0] tbl_end   [REGIONS];
    logic [31:0] tbl_id    [REGIONS];
    logic [15:0] tbl_owner [REGIONS];
    bit          tbl_valid [REGIONS];

    art_out_t     expected_results[$];
    region_case_t dir_cases[N_DIRECTED];
    logic [31:0]  id_pool[4];
    logic [15:0]  owner_pool[4];
    logic [47:0]  zone_base[4];
    bit           tx_gaps_on;
    int           err_count;
    int           sent_count;
    int           result_count;
    int           hit_count;
    int           status_seen[8];

    address_region_table u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin : watchdog
        #(10_000_000);
        $display("Timeout: %0d results still outstanding", expected_results.size());
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0];
    endfunction

    // Applies one request to the shadow table and returns the result it yields
    function automatic art_out_t region_table_apply(art_in_t req);
        art_out_t    res;
        logic [48:0] last_ext;
        int          i;
        int          slot;
        int          best;
        bit          clash;
        bit          found;
        res               = '0;
        res.status        = ST_NOTFOUND;
        res.probe_address = req.address;
        slot              = -1;
        best              = -1;
        clash             = 1'b0;
        found             = 1'b0;
        case (req.command)
            CMD_ATTACH:
            begin
                last_ext = {1'b0, req.address} + {1'b0, req.length} - 49'd1;
                if (req.length == '0 || last_ext[48])
                    res.status = ST_BADLEN;
                else
                begin
                    for (i = 0; i < REGIONS; i++)
                    begin
                        if (tbl_valid[i])
                        begin
                            if (req.address <= tbl_end[i] && tbl_start[i] <= last_ext[47:0])
                                clash = 1'b1;
                        end
                        else if (slot < 0)
                            slot = i;
                    end
                    if (clash)
                        res.status = ST_CONFLICT;
                    else if (slot < 0)
                        res.status = ST_FULL;
                    else
                    begin
                        tbl_start[slot] = req.address;
                        tbl_end[slot]   = last_ext[47:0];
                        tbl_id[slot]    = req.region_id;
                        tbl_owner[slot] = req.owner_tag;
                        tbl_valid[slot] = 1'b1;
                        res.status      = ST_OK;
                    end
                end
            end
            CMD_DETACH:
            begin
                for (i = 0; i < REGIONS; i++)
                    if (tbl_valid[i] && tbl_id[i] == req.region_id
                        && tbl_owner[i] == req.owner_tag)
                        if (best < 0 || tbl_start[i] < tbl_start[best])
                            best = i;
                if (best >= 0)
                begin
                    tbl_valid[best] = 1'b0;
                    res.status      = ST_OK;
                end
            end
            CMD_LOOKUP:
            begin
                for (i = 0; i < REGIONS; i++)
                    if (!found && tbl_valid[i] && tbl_start[i] <= req.address
                        && req.address <= tbl_end[i])
                    begin
                        found           = 1'b1;
                        res.status      = ST_OK;
                        res.hit         = 1'b1;
                        res.match_id    = tbl_id[i];
                        res.match_owner = tbl_owner[i];
                    end
            end
            default:
                res.status = ST_NOTFOUND;
        endcase
        return res;
    endfunction

    function automatic region_case_t case_row(logic [1:0] cmd, logic [31:0] id,
                                              logic [15:0] owner, logic [47:0] addr,
                                              logic [47:0] len, int reps,
                                              logic [47:0] stride, bit typed,
                                              logic [2:0] st, logic hit,
                                              logic [31:0] mid, logic [15:0] mown);
        region_case_t row;
        row.req.command       = cmd;
        row.req.region_id     = id;
        row.req.owner_tag     = owner;
        row.req.address       = addr;
        row.req.length        = len;
        row.reps              = reps;
        row.stride            = stride;
        row.typed             = typed;
        row.res.status        = st;
        row.res.hit           = hit;
        row.res.match_id      = mid;
        row.res.match_owner   = mown;
        row.res.probe_address = addr;
        return row;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!tx_gaps_on || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(30, 60);
    endfunction

    // Mostly well-formed traffic: attaches packed into a few zones so the table fills
    // and collides, detaches and lookups aimed at ranges that are actually stored.
    function automatic art_in_t random_request(int attach_w, int detach_w);
        art_in_t     req;
        int          live[$];
        int          i;
        int          r;
        int          p;
        int          j;
        logic [48:0] span1;
        logic [48:0] off;
        for (i = 0; i < REGIONS; i++)
            if (tbl_valid[i])
                live.push_back(i);
        j                 = $urandom_range(0, 3);
        req.command       = CMD_LOOKUP;
        req.region_id     = $urandom;
        req.owner_tag     = 16'($urandom_range(0, 65535));
        req.address       = rand48();
        req.length        = rand48();
        r                 = $urandom_range(0, 99);
        if (r < attach_w)
        begin
            req.command = CMD_ATTACH;
            if ($urandom_range(0, 4) != 0)
            begin
                req.region_id = id_pool[j];
                req.owner_tag = ($urandom_range(0, 3) != 0) ? owner_pool[j]
                                                           : owner_pool[$urandom_range(0, 3)];
            end
            r = $urandom_range(0, 9);
            if (r < 7)
            begin
                req.address = zone_base[$urandom_range(0, 3)] + 48'($urandom_range(0, 8191));
                req.length  = 48'($urandom_range(1, 512));
            end
            else if (r < 8)
                req.length = $urandom_range(0, 1) ? '0 : ADDR_MAX - 48'($urandom_range(0, 15));
            else
                req.length = rand48() >> $urandom_range(0, 47);
        end
        else if (r < attach_w + detach_w)
        begin
            req.command = CMD_DETACH;
            if (live.size() > 0 && $urandom_range(0, 3) != 0)
            begin
                p             = live[$urandom_range(0, live.size() - 1)];
                req.region_id = tbl_id[p];
                req.owner_tag = tbl_owner[p];
                if ($urandom_range(0, 7) == 0)
                    req.owner_tag = req.owner_tag ^ (16'h1 << $urandom_range(0, 15));
            end
            else if ($urandom_range(0, 1) != 0)
            begin
                req.region_id = id_pool[j];
                req.owner_tag = owner_pool[j];
            end
        end
        else if (r < 96)
        begin
            if (live.size() > 0 && $urandom_range(0, 2) != 0)
            begin
                p     = live[$urandom_range(0, live.size() - 1)];
                span1 = {1'b0, tbl_end[p]} - {1'b0, tbl_start[p]} + 49'd1;
                off   = {1'b0, rand48()} % span1;
                case ($urandom_range(0, 4))
                    0: req.address = tbl_start[p];
                    1: req.address = tbl_end[p];
                    2: req.address = tbl_start[p] - 48'd1;
                    3: req.address = tbl_end[p] + 48'd1;
                    default: req.address = tbl_start[p] + off[47:0];
                endcase
            end
            else if ($urandom_range(0, 1) != 0)
                req.address = zone_base[$urandom_range(0, 3)] + 48'($urandom_range(0, 8191));
        end
        else
            req.command = CMD_UNUSED;
        return req;
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_request(art_in_t req, bit typed, art_out_t typed_res);
        int       gap;
        art_out_t model_res;
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_data  <= req;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        model_res = region_table_apply(req);
        expected_results.push_back(typed ? typed_res : model_res);
        sent_count++;
        @(negedge clk);
    endtask

    initial
    begin : result_backpressure
        int n_stall;
        int n_ready;
        int r;
        res_stall = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                n_stall = 0;
                n_ready = $urandom_range(100, 300);
            end
            else
            begin
                n_ready = $urandom_range(1, 6);
                r       = $urandom_range(0, 99);
                if (r < 50)
                    n_stall = 0;
                else if (r < 90)
                    n_stall = $urandom_range(1, 3);
                else if (r < 98)
                    n_stall = $urandom_range(4, 15);
                else
                    n_stall = $urandom_range(30, 60);
            end
            if (n_stall > 0)
            begin
                res_stall <= 1'b1;
                repeat (n_stall) @(negedge clk);
                res_stall <= 1'b0;
            end
            repeat (n_ready) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        art_out_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            result_count++;
            status_seen[res_data.status]++;
            if (res_data.hit)
                hit_count++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transfer, status %0d", res_data.status);
                err_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (res_data.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, res_data.status);
                    err_count++;
                end
                if (res_data.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, res_data.hit);
                    err_count++;
                end
                if (res_data.match_id !== want.match_id)
                begin
                    $error("match_id: expected %h, got %h", want.match_id, res_data.match_id);
                    err_count++;
                end
                if (res_data.match_owner !== want.match_owner)
                begin
                    $error("match_owner: expected %h, got %h",
                           want.match_owner, res_data.match_owner);
                    err_count++;
                end
                if (res_data.probe_address !== want.probe_address)
                begin
                    $error("probe_address: expected %h, got %h",
                           want.probe_address, res_data.probe_address);
                    err_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        int          i;
        int          k;
        int          ph;
        int          attach_w;
        int          detach_w;
        art_in_t     req;
        rst_n      = 1'b0;
        cmd_valid  = 1'b0;
        cmd_data   = '0;
        tx_gaps_on = 1'b1;
        err_count  = 0;
        sent_count = 0;
        result_count = 0;
        hit_count  = 0;
        for (i = 0; i < 8; i++)
            status_seen[i] = 0;
        for (i = 0; i < REGIONS; i++)
        begin
            tbl_start[i] = '0;
            tbl_end[i]   = '0;
            tbl_id[i]    = '0;
            tbl_owner[i] = '0;
            tbl_valid[i] = 1'b0;
        end
        for (i = 0; i < 4; i++)
        begin
            id_pool[i]    = $urandom;
            owner_pool[i] = 16'($urandom_range(0, 65535));
        end
        zone_base[0] = '0;
        zone_base[1] = rand48();
        zone_base[2] = rand48();
        zone_base[3] = ADDR_MAX - 48'hFFF;   // near the top, so some attaches wrap

        // Slots 0 and 1 hold the top byte and [0, FF]; the repeated attach fills
        // slots 2..15 at falling addresses, so the lowest address sits in the last slot.
        dir_cases[0]  = case_row(CMD_LOOKUP, 0, 0, 0, 0, 1, 0, 1, ST_NOTFOUND, 0, 0, 0);
        dir_cases[1]  = case_row(CMD_DETACH, 0, 0, 0, 0, 1, 0, 1, ST_NOTFOUND, 0, 0, 0);
        dir_cases[2]  = case_row(CMD_ATTACH, 32'h1, 16'h1, 48'h1000, 0, 1, 0,
                                 1, ST_BADLEN, 0, 0, 0);
        dir_cases[3]  = case_row(CMD_ATTACH, 32'h2, 16'h2, ADDR_MAX, 48'h2, 1, 0,
                                 1, ST_BADLEN, 0, 0, 0);
        dir_cases[4]  = case_row(CMD_ATTACH, '1, '1, ADDR_MAX, 48'h1, 1, 0,
                                 1, ST_OK, 0, 0, 0);
        dir_cases[5]  = case_row(CMD_ATTACH, 0, 0, 48'h1, ADDR_MAX, 1, 0,
                                 1, ST_CONFLICT, 0, 0, 0);
        dir_cases[6]  = case_row(CMD_ATTACH, 0, 0, 0, 48'h100, 1, 0, 1, ST_OK, 0, 0, 0);
        dir_cases[7]  = case_row(CMD_LOOKUP, 0, 0, ADDR_MAX, 0, 1, 0,
                                 1, ST_OK, 1, '1, '1);
        dir_cases[8]  = case_row(CMD_LOOKUP, 0, 0, 48'hFF, 0, 1, 0, 1, ST_OK, 1, 0, 0);
        dir_cases[9]  = case_row(CMD_UNUSED, 32'h5A5A_5A5A, 16'hA5A5, 48'h8000_0000_0001,
                                 48'h7FFF_FFFF_FFFF, 1, 0, 1, ST_NOTFOUND, 0, 0, 0);
        dir_cases[10] = case_row(CMD_ATTACH, 32'hA5A5_A5A5, 16'h5A5A, 48'h1000_2000,
                                 48'h40, REGIONS - 2, 48'h1000, 0, ST_OK, 0, 0, 0);
        dir_cases[11] = case_row(CMD_ATTACH, 32'h7, 16'h7, 48'h4000_0000, 48'h4, 1, 0,
                                 1, ST_FULL, 0, 0, 0);
        dir_cases[12] = case_row(CMD_ATTACH, 32'h7, 16'h7, 48'h80, 48'h200, 1, 0,
                                 1, ST_CONFLICT, 0, 0, 0);
        dir_cases[13] = case_row(CMD_DETACH, 32'hA5A5_A5A5, 16'h5A5A, 0, 0, 1, 0,
                                 1, ST_OK, 0, 0, 0);
        dir_cases[14] = case_row(CMD_LOOKUP, 0, 0, 48'h0FFF_5000, 0, 1, 0,
                                 1, ST_NOTFOUND, 0, 0, 0);
        dir_cases[15] = case_row(CMD_LOOKUP, 0, 0, 48'h1000_2000, 0, 1, 0,
                                 1, ST_OK, 1, 32'hA5A5_A5A5, 16'h5A5A);
        dir_cases[16] = case_row(CMD_LOOKUP, 0, 0, 48'h100, 0, 1, 0,
                                 1, ST_NOTFOUND, 0, 0, 0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (i = 0; i < N_DIRECTED; i++)
            for (k = 0; k < dir_cases[i].reps; k++)
            begin
                req         = dir_cases[i].req;
                req.address = req.address - 48'(k) * dir_cases[i].stride;
                send_request(req, dir_cases[i].typed, dir_cases[i].res);
            end

        // Phases rotate through filling, draining and mixed traffic; every fourth
        // phase runs back to back with no sender gaps.
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            tx_gaps_on = (ph % 4 != 3);
            case (ph % 3)
                0:
                begin
                    attach_w = 55;
                    detach_w = 15;
                end
                1:
                begin
                    attach_w = 25;
                    detach_w = 45;
                end
                default:
                begin
                    attach_w = 40;
                    detach_w = 28;
                end
            endcase
            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                req = random_request(attach_w, detach_w);
                send_request(req, 1'b0, '0);
            end
        end
        cmd_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests, checked %0d results, %0d lookup hits",
                 sent_count, result_count, hit_count);
        $display("Status mix: ok %0d, conflict %0d, full %0d, not found %0d, bad length %0d",
                 status_seen[ST_OK], status_seen[ST_CONFLICT], status_seen[ST_FULL],
                 status_seen[ST_NOTFOUND], status_seen[ST_BADLEN]);
        if (err_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[files.f]
src/art_pkg.sv
src/art_ctrl.sv
src/art_dp.sv
src/address_region_table.sv
verif/address_region_table_test.sv
